>>> rtl/core/hamming_encode_correct_core_assert.svh
// Assertion macros for the Hamming encode/correct core checker.
// No dependencies; included by the checker file.
`ifndef HAMMING_ENCODE_CORRECT_CORE_ASSERT_SVH
`define HAMMING_ENCODE_CORRECT_CORE_ASSERT_SVH

// Checked only while out of reset.
`define HEC_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: %m");

// Checked at every edge, reset included.
`define HEC_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("assertion failed: %m");

`endif

>>> rtl/core/hec_pkg.sv
// Package for the Hamming encode/correct core: beat types, widths and
// code-layout helper functions. No dependencies.
package hec_pkg;

    localparam int DATA_BITS_DEF = 11;
    localparam int WORD_W        = 15;
    localparam int SYN_W         = 4;
    localparam int CW_MAX        = 64;
    localparam int POS_W         = 7;

    typedef struct packed {
        logic              action;
        logic [WORD_W-1:0] word;
    } in_beat_t;

    typedef struct packed {
        logic [WORD_W-1:0] code_out;
        logic [SYN_W-1:0]  syndrome;
        logic              error_found;
        logic              out_of_range;
    } out_beat_t;

    typedef enum logic {
        ACT_ENCODE = 1'b0,
        ACT_DECODE = 1'b1
    } action_t;

    function automatic int check_count(input int data_bits);
        int r;
        r = 0;
        while ((1 << r) < data_bits + r + 1)
            r++;
        return r;
    endfunction

    function automatic bit is_pow2(input int p);
        return (p != 0) && ((p & (p - 1)) == 0);
    endfunction

    // data bit index carried at non-power-of-two position p
    function automatic int data_index(input int p);
        int k;
        k = 0;
        for (int q = 1; q < p; q++)
            if (!is_pow2(q))
                k++;
        return k;
    endfunction

    // positions covered by check bit b
    function automatic logic [CW_MAX-1:0] syn_mask(input int b);
        logic [CW_MAX-1:0] m;
        m = '0;
        for (int p = 1; p <= CW_MAX; p++)
            if (((p >> b) & 1) != 0)
                m[p-1] = 1'b1;
        return m;
    endfunction

endpackage

>>> rtl/core/hamming_encode_correct_core.sv
// Hamming SEC encode/correct core. Three register stages lie between req beat and
// rsp beat: layout, syndrome and correction.
// Throughput: one beat per cycle; the three stages stall together only when
// all hold a beat and rsp is back-pressured.
// Reset: rst_n asynchronous, clears the stage valid bits; payload not reset.
// Depends on hec_pkg, hec_layout, hec_syndrome, hec_correct.
module hamming_encode_correct_core
    import hec_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  in_beat_t  req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output out_beat_t rsp
);

    localparam int R = check_count(DATA_BITS);
    localparam int N = DATA_BITS + R;

    logic         s1_valid;
    logic         s1_ready;
    logic         s1_action;
    logic [N-1:0] s1_cw;
    logic         s2_valid;
    logic         s2_ready;
    logic         s2_action;
    logic [N-1:0] s2_cw;
    logic [R-1:0] s2_syn;

    hec_layout #(
        .DATA_BITS(DATA_BITS)
    ) u_layout (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .out_valid  (s1_valid),
        .out_ready  (s1_ready),
        .out_action (s1_action),
        .out_cw     (s1_cw)
    );

    hec_syndrome #(
        .DATA_BITS(DATA_BITS)
    ) u_syndrome (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s1_valid),
        .in_ready   (s1_ready),
        .in_action  (s1_action),
        .in_cw      (s1_cw),
        .out_valid  (s2_valid),
        .out_ready  (s2_ready),
        .out_action (s2_action),
        .out_cw     (s2_cw),
        .out_syn    (s2_syn)
    );

    hec_correct #(
        .DATA_BITS(DATA_BITS)
    ) u_correct (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_action (s2_action),
        .in_cw     (s2_cw),
        .in_syn    (s2_syn),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

>>> rtl/core/hec_layout.sv
// Stage 1: places the data bits at their codeword positions (encode) or
// masks the received codeword (decode). Depends on hec_pkg.
module hec_layout
    import hec_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  in_beat_t             req,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_action,
    output logic [DATA_BITS+check_count(DATA_BITS)-1:0] out_cw
);

    localparam int R = check_count(DATA_BITS);
    localparam int N = DATA_BITS + R;

    logic         valid_reg;
    logic         action_reg;
    logic [N-1:0] cw_reg;
    logic [N-1:0] cw_next;

    assign req_ready = !valid_reg || out_ready;

    always_comb
    begin
        cw_next = '0;
        if (req.action == ACT_ENCODE)
        begin
            for (int p = 1; p <= N; p++)
            begin
                if (!is_pow2(p) && data_index(p) < WORD_W)
                    cw_next[p-1] = req.word[data_index(p)];
            end
        end
        else
        begin
            for (int i = 0; i < N && i < WORD_W; i++)
                cw_next[i] = req.word[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (req_ready)
            valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            action_reg <= req.action;
            cw_reg     <= cw_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_action = action_reg;
    assign out_cw     = cw_reg;

endmodule

>>> rtl/core/hec_syndrome.sv
// Stage 2: parity trees forming the syndrome over the laid-out codeword.
// Depends on hec_pkg.
module hec_syndrome
    import hec_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_action,
    input  logic [DATA_BITS+check_count(DATA_BITS)-1:0] in_cw,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_action,
    output logic [DATA_BITS+check_count(DATA_BITS)-1:0] out_cw,
    output logic [check_count(DATA_BITS)-1:0]           out_syn
);

    localparam int R = check_count(DATA_BITS);
    localparam int N = DATA_BITS + R;

    logic         valid_reg;
    logic         action_reg;
    logic [N-1:0] cw_reg;
    logic [R-1:0] syn_reg;
    logic [R-1:0] syn_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        logic [CW_MAX-1:0] m;
        m = '0;
        for (int b = 0; b < R; b++)
        begin
            m           = syn_mask(b);
            syn_next[b] = ^(in_cw & m[N-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            action_reg <= in_action;
            cw_reg     <= in_cw;
            syn_reg    <= syn_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_action = action_reg;
    assign out_cw     = cw_reg;
    assign out_syn    = syn_reg;

endmodule

>>> rtl/core/hec_correct.sv
// Stage 3: inserts check bits (encode) or flips the flagged bit (decode),
// then the output register. Depends on hec_pkg.
module hec_correct
    import hec_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_action,
    input  logic [DATA_BITS+check_count(DATA_BITS)-1:0] in_cw,
    input  logic [check_count(DATA_BITS)-1:0]           in_syn,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output out_beat_t            rsp
);

    localparam int R = check_count(DATA_BITS);
    localparam int N = DATA_BITS + R;

    logic              valid_reg;
    out_beat_t         rsp_reg;
    out_beat_t         rsp_next;
    logic [N-1:0]      cw_fix;
    logic [CW_MAX-1:0] cw_wide;
    logic [POS_W-1:0]  syn_pos;
    logic [7:0]        syn_wide;

    assign in_ready = !valid_reg || rsp_ready;

    always_comb
    begin
        syn_pos  = POS_W'(in_syn);
        syn_wide = 8'(in_syn);
        cw_fix   = in_cw;
        if (in_action == ACT_ENCODE)
        begin
            for (int b = 0; b < R; b++)
                cw_fix[(1 << b) - 1] = in_syn[b];
        end
        else
        begin
            for (int i = 0; i < N; i++)
            begin
                if (syn_pos == POS_W'(i + 1))
                    cw_fix[i] = ~in_cw[i];
            end
        end
        cw_wide               = CW_MAX'(cw_fix);
        rsp_next.code_out     = cw_wide[WORD_W-1:0];
        rsp_next.syndrome     = (in_action == ACT_DECODE) ? syn_wide[SYN_W-1:0] : '0;
        rsp_next.error_found  = (in_action == ACT_DECODE) && (in_syn != '0);
        rsp_next.out_of_range = (in_action == ACT_DECODE) && (syn_pos > POS_W'(N));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> rtl/core/hec_checker.sv
// Port-level checker for hamming_encode_correct_core, bound to the top level.
// Depends on hec_pkg and hamming_encode_correct_core_assert.svh.
`include "hamming_encode_correct_core_assert.svh"

module hec_checker
    import hec_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_ready,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input out_beat_t rsp
);

    // input side only stalls when the whole pipe is full and rsp is stalled
    `HEC_ASSERT(a_req_stall_cause, clk, rst_n, !req_ready |-> (rsp_valid && !rsp_ready))
    `HEC_ASSERT(a_rsp_hold, clk, rst_n, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    `HEC_ASSERT(a_oor_err, clk, rst_n, (rsp_valid && rsp.out_of_range) |-> rsp.error_found)
    // valid bits are cleared asynchronously as soon as rst_n is low, so this holds in reset too
    `HEC_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !rsp_valid)

endmodule

bind hamming_encode_correct_core hec_checker u_hec_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

>>> sim/hamming_encode_correct_core_check.sv
// Checker for hamming_encode_correct_core: watches both beat channels, predicts each
// response from the request beat and compares field by field.
// Depends on hec_pkg.
module hamming_encode_correct_core_check
    import hec_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_ready,
    input  in_beat_t  req,
    input  logic      rsp_valid,
    input  logic      rsp_ready,
    input  out_beat_t rsp,
    output int        fault_count,
    output int        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    function automatic int parity_bits(input int d);
        int r;
        r = 0;
        while ((64'd1 << r) < d + r + 1)
            r++;
        return r;
    endfunction

    localparam int CHK_BITS = parity_bits(DATA_BITS);
    localparam int CW_LEN   = DATA_BITS + CHK_BITS;

    out_beat_t awaited_codes[$];

    function automatic int group_parity(input logic [63:0] cw);
        int  s;
        bit  par;
        s = 0;
        for (int b = 0; b < CHK_BITS; b++)
        begin
            par = 1'b0;
            for (int p = 1; p <= CW_LEN; p++)
                if (((p >> b) & 1) != 0)
                    par ^= cw[p-1];
            s |= int'(par) << b;
        end
        return s;
    endfunction

    function automatic out_beat_t coded_word(input in_beat_t b);
        logic [63:0] cw;
        int          k;
        int          s;
        out_beat_t   o;
        cw = '0;
        k  = 0;
        if (action_t'(b.action) == ACT_ENCODE)
        begin
            // data fills the non power-of-two positions, excess input bits dropped
            for (int p = 1; p <= CW_LEN; p++)
                if ((p & (p - 1)) != 0)
                begin
                    if (k < WORD_W)
                        cw[p-1] = b.word[k];
                    k++;
                end
            s = group_parity(cw);
            for (int i = 0; i < CHK_BITS; i++)
                if (s[i])
                    cw[(1 << i) - 1] = 1'b1;
            s = 0;
            o.error_found  = 1'b0;
            o.out_of_range = 1'b0;
        end
        else
        begin
            for (int p = 0; p < WORD_W; p++)
                if (p < CW_LEN)
                    cw[p] = b.word[p];
            s = group_parity(cw);
            o.error_found  = (s != 0);
            o.out_of_range = (s > CW_LEN);
            if (s != 0 && s <= CW_LEN)
                cw[s-1] = ~cw[s-1];
        end
        o.code_out = cw[WORD_W-1:0];
        o.syndrome = s[SYN_W-1:0];
        return o;
    endfunction

    task automatic report_fault(input string what);
        fault_count++;
        $display("%0t ns  mismatch: %s", $realtime, what);
    endtask

    initial
    begin
        fault_count = 0;
        outstanding = 0;
    end

    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n)
        begin
            if (req_valid && req_ready)
                awaited_codes.push_back(coded_word(req));
            if (rsp_valid && rsp_ready)
            begin
                if (awaited_codes.size() == 0)
                    report_fault("response beat with nothing outstanding");
                else
                begin
                    want = awaited_codes.pop_front();
                    if (rsp.code_out !== want.code_out)
                        report_fault($sformatf("code_out %h, want %h",
                                               rsp.code_out, want.code_out));
                    if (rsp.syndrome !== want.syndrome)
                        report_fault($sformatf("syndrome %h, want %h",
                                               rsp.syndrome, want.syndrome));
                    if (rsp.error_found !== want.error_found)
                        report_fault($sformatf("error_found %b, want %b",
                                               rsp.error_found, want.error_found));
                    if (rsp.out_of_range !== want.out_of_range)
                        report_fault($sformatf("out_of_range %b, want %b",
                                               rsp.out_of_range, want.out_of_range));
                end
            end
            outstanding = awaited_codes.size();
        end
    end

endmodule

>>> sim/hamming_encode_correct_core_test.sv
// Top of the hamming_encode_correct_core testbench: clock, reset, request and
// response stimulus, verdict. Depends on hec_pkg and hamming_encode_correct_core_check.
module hamming_encode_correct_core_test
    import hec_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    in_beat_t  req       = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    out_beat_t rsp;
    int        fault_count;
    int        outstanding;
    int        tx_idle_pct = 19;
    int        rx_idle_pct = 74;
    bit        rx_hold     = 1'b0;

    hamming_encode_correct_core #(
        .DATA_BITS (DATA_BITS_DEF)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    hamming_encode_correct_core_check #(
        .DATA_BITS (DATA_BITS_DEF)
    ) coding_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .fault_count (fault_count),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("hamming_encode_correct_core_test: done, errors");
        $finish;
    end

    // response side: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold)
            begin
                rsp_ready <= 1'b0;
                repeat (40) @(negedge clk);
                rx_hold = 1'b0;
            end
            rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic push_beat(input action_t act, input logic [WORD_W-1:0] w);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid  <= 1'b1;
        req.action <= act;
        req.word   <= w;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic random_run(input int count);
        for (int i = 0; i < count; i++)
            push_beat(action_t'($urandom_range(0, 1)), WORD_W'($urandom_range(0, 32767)));
    endtask

    task automatic drain_all();
        @(negedge clk);
        req_valid <= 1'b0;
        wait (outstanding == 0);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // encode: zero, full data, excess bits only and with data, alternating
        push_beat(ACT_ENCODE, 15'h0000);
        push_beat(ACT_ENCODE, 15'h07FF);
        push_beat(ACT_ENCODE, 15'h7FFF);
        push_beat(ACT_ENCODE, 15'h7800);
        push_beat(ACT_ENCODE, 15'h0555);
        push_beat(ACT_ENCODE, 15'h02AA);
        // decode: clean codewords, single errors on the all-ones word, then a single error at every position
        push_beat(ACT_DECODE, 15'h0000);
        push_beat(ACT_DECODE, 15'h7FFF);
        push_beat(ACT_DECODE, 15'h7FFE);
        push_beat(ACT_DECODE, 15'h3FFF);
        for (int i = 0; i < WORD_W; i++)
            push_beat(ACT_DECODE, WORD_W'(1 << i));

        random_run(170);
        drain_all();

        tx_idle_pct = 74;
        rx_idle_pct = 19;
        random_run(170);
        drain_all();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold     = 1'b1;
        random_run(12);
        wait (!rx_hold);
        random_run(170);
        drain_all();

        repeat (10) @(posedge clk);
        if (fault_count == 0)
            $display("hamming_encode_correct_core_test: done, clean");
        else
            $display("hamming_encode_correct_core_test: done, errors");
        $finish;
    end

endmodule

>>> hamming_encode_correct_core.f
+incdir+rtl/core
rtl/core/hec_pkg.sv
rtl/core/hec_layout.sv
rtl/core/hec_syndrome.sv
rtl/core/hec_correct.sv
rtl/core/hamming_encode_correct_core.sv
rtl/core/hec_checker.sv
sim/hamming_encode_correct_core_check.sv
sim/hamming_encode_correct_core_test.sv
